/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define DRGI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define DRGI_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DRGI_ASSERT(lbl, clk, rst_n, prop, msg)
`define DRGI_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* design/drgi_pkg.sv */
// ----------------------------------------------------------------------------
// drgi_pkg
// Shared widths, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package drgi_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int MAX_GAP    = 63;
    // gap counter width is fixed by the held-count state
    localparam int GAP_W      = 6;
    localparam int DEN_W      = GAP_W + 1;
    // L*den + den/2 stays below 2^(DEPTH_BITS+GAP_W)
    localparam int ACC_W      = DEPTH_BITS + GAP_W;

    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [GAP_W-1:0]      t_gap;
    typedef logic [DEN_W-1:0]      t_den;
    typedef logic [ACC_W-1:0]      t_acc;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request payload
        logic setup;     // work out gap count and interpolation start
        logic step;      // advance accumulator, start divider
        logic flat_out;  // load flat gap pixel into output
        logic div_out;   // load interpolated pixel into output
        logic val_out;   // load the measured pixel into output
        logic adv;       // next gap pixel
        logic commit;    // update row state, request done
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic more;      // gap pixels left to emit
        logic interp;    // gap pixels are interpolated
        logic in_valid;  // request carries a measured pixel
        logic out_last;  // output register holds last result of request
        logic div_done;  // divider quotient ready
    } t_status;

endpackage

`default_nettype wire

/* design/drgi_div.sv */
// ----------------------------------------------------------------------------
// drgi_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit DEPTH_BITS, so the upper dividend bits seed the remainder directly.
// ----------------------------------------------------------------------------
`default_nettype none

module drgi_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire drgi_pkg::t_acc  i_dividend,
    input  wire drgi_pkg::t_den  i_divisor,
    output logic                 o_done,
    output drgi_pkg::t_depth     o_quotient
);
    import drgi_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_BITS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    t_den             r_rem;
    t_den             r_div;
    t_depth           r_low;
    t_depth           r_quo;

    logic [DEN_W:0]   w_trial;
    logic             w_fits;
    t_den             w_rem_sub;

    // trial subtraction of one bit
    always_comb begin
        w_trial   = {r_rem, r_low[DEPTH_BITS-1]};
        w_fits    = (w_trial >= {1'b0, r_div});
        w_rem_sub = DEN_W'(w_trial - {1'b0, r_div});
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DEPTH_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[ACC_W-1:DEPTH_BITS]};
            r_low <= i_dividend[DEPTH_BITS-1:0];
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_rem_sub : DEN_W'(w_trial);
            r_low <= {r_low[DEPTH_BITS-2:0], 1'b0};
            r_quo <= {r_quo[DEPTH_BITS-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* design/drgi_datapath.sv */
// ----------------------------------------------------------------------------
// drgi_datapath
// Row state, gap counters, interpolation accumulator, divider and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drgi_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire drgi_pkg::t_cmd    i_cmd,
    input  wire drgi_pkg::t_depth  i_depth_value,
    input  wire logic              i_depth_valid,
    input  wire logic              i_row_end,
    output drgi_pkg::t_status      o_status,
    output drgi_pkg::t_depth       o_filled_depth,
    output logic                   o_was_filled,
    output logic                   o_no_neighbour,
    output logic                   o_row_last,
    output logic                   o_burst_last
);
    import drgi_pkg::*;

    // row state
    t_depth r_left;
    logic   r_seen;
    t_gap   r_gap;

    // captured request
    t_depth r_val;
    logic   r_vld;
    logic   r_rend;

    // per-request work
    t_gap   r_cnt;
    t_gap   r_k;
    t_den   r_den;
    t_acc   r_acc;

    // output register
    t_depth r_out_depth;
    logic   r_out_filled;
    logic   r_out_nonb;
    logic   r_out_last;

    t_gap   w_new_gap;
    logic   w_flush;
    t_den   w_den;
    logic [DEPTH_BITS+DEN_W-1:0] w_prod;
    t_acc   n_acc;
    logic   w_k_last;
    logic   w_div_done;
    t_depth w_quo;

    always_comb begin
        w_new_gap = r_gap + 1'b1;
        w_flush   = !r_vld && (r_rend || ({1'b0, w_new_gap} >= DEN_W'(MAX_GAP)));
        w_den     = {1'b0, r_gap} + 1'b1;
        w_prod    = r_left * w_den;
        n_acc     = r_acc + ACC_W'(r_val) - ACC_W'(r_left);
        w_k_last  = (({1'b0, r_k} + 1'b1) == {1'b0, r_cnt});
    end

    drgi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.step),
        .i_dividend (n_acc),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // row state, cleared at reset and after a row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_seen <= 1'b0;
            r_gap  <= '0;
        end else if (i_cmd.commit) begin
            if (r_rend) begin
                r_left <= '0;
                r_seen <= 1'b0;
                r_gap  <= '0;
            end else if (r_vld) begin
                r_left <= r_val;
                r_seen <= 1'b1;
                r_gap  <= '0;
            end else if (r_cnt != '0) begin
                r_gap <= '0;
            end else begin
                r_gap <= w_new_gap;
            end
        end
    end

    // request capture and gap work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_depth_value;
            r_vld  <= i_depth_valid;
            r_rend <= i_row_end;
        end
        if (i_cmd.setup) begin
            r_k   <= '0;
            r_den <= w_den;
            // start at L*den + den/2; each step adds R - L
            r_acc <= ACC_W'(w_prod) + ACC_W'(w_den >> 1);
            if (r_vld) begin
                r_cnt <= r_gap;
            end else if (w_flush) begin
                r_cnt <= w_new_gap;
            end else begin
                r_cnt <= '0;
            end
        end
        if (i_cmd.step) begin
            r_acc <= n_acc;
        end
        if (i_cmd.adv) begin
            r_k <= r_k + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.flat_out) begin
            r_out_filled <= 1'b1;
            r_out_last   <= !r_vld && w_k_last;
            if (r_vld) begin
                r_out_depth <= r_val;
                r_out_nonb  <= 1'b0;
            end else if (r_seen) begin
                r_out_depth <= r_left;
                r_out_nonb  <= 1'b0;
            end else begin
                r_out_depth <= '0;
                r_out_nonb  <= 1'b1;
            end
        end else if (i_cmd.div_out) begin
            r_out_depth  <= w_quo;
            r_out_filled <= 1'b1;
            r_out_nonb   <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (i_cmd.val_out) begin
            r_out_depth  <= r_val;
            r_out_filled <= 1'b0;
            r_out_nonb   <= 1'b0;
            r_out_last   <= 1'b1;
        end
    end

    always_comb begin
        o_status.more     = (r_k < r_cnt);
        o_status.interp   = r_vld && r_seen;
        o_status.in_valid = r_vld;
        o_status.out_last = r_out_last;
        o_status.div_done = w_div_done;
    end

    assign o_filled_depth = r_out_depth;
    assign o_was_filled   = r_out_filled;
    assign o_no_neighbour = r_out_nonb;
    assign o_burst_last   = r_out_last;
    assign o_row_last     = r_out_last && r_rend;

endmodule

`default_nettype wire

/* design/drgi_ctrl.sv */
// ----------------------------------------------------------------------------
// drgi_ctrl
// Sequencer: takes one request, walks its gap pixels through the datapath
// and hands each result to the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module drgi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire drgi_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output drgi_pkg::t_cmd         o_cmd
);
    import drgi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_NEXT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_NEXT;
            end
            S_NEXT: begin
                if (i_status.more) begin
                    if (i_status.interp) begin
                        o_cmd.step = 1'b1;
                        n_state    = S_DIV;
                    end else begin
                        o_cmd.flat_out = 1'b1;
                        n_state        = S_EMIT;
                    end
                end else if (i_status.in_valid) begin
                    o_cmd.val_out = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    // invalid pixel inside a gap: nothing to send
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_out = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

`default_nettype wire

/* design/depth_row_gap_interpolator.sv */
// ----------------------------------------------------------------------------
// depth_row_gap_interpolator
// Fills runs of missing depth pixels within an image row by linear
// interpolation between the valid neighbours.
//
// Input channel (i_in_valid / o_in_ready) takes one pixel per request with
// its valid flag and row-end mark. Output channel (o_out_valid / i_out_ready)
// delivers zero or more result pixels per request; o_burst_last marks the
// last one, o_row_last the last of a row.
// One request is handled at a time. A measured pixel with no held gap passes
// through the setup and next states before its result is shown, and the
// block is ready again in the cycle after that result is taken. Each flat
// gap pixel (leading, trailing or flushed gap) goes from the next state to
// the emit state; each interpolated gap pixel also waits in the divide state
// for the one-bit-per-cycle divider. A missing pixel inside a gap gives no
// result. A stalled receiver holds the result in the output register and the
// sequencer waits; no input is taken meanwhile.
// Reset (synchronous, active low) clears the row state and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module depth_row_gap_interpolator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire drgi_pkg::t_depth  i_depth_value,
    input  wire logic              i_depth_valid,
    input  wire logic              i_row_end,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output drgi_pkg::t_depth       o_filled_depth,
    output logic                   o_was_filled,
    output logic                   o_no_neighbour,
    output logic                   o_row_last,
    output logic                   o_burst_last
);
    import drgi_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    drgi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    drgi_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_depth_value  (i_depth_value),
        .i_depth_valid  (i_depth_valid),
        .i_row_end      (i_row_end),
        .o_status       (w_status),
        .o_filled_depth (o_filled_depth),
        .o_was_filled   (o_was_filled),
        .o_no_neighbour (o_no_neighbour),
        .o_row_last     (o_row_last),
        .o_burst_last   (o_burst_last)
    );

    // one request in flight: never ready for input while a result is shown
    `DRGI_NEVER(a_no_overlap, i_clk, i_rst_n, o_in_ready && o_out_valid, "ready while emitting")
    // a pixel with no neighbour is a filled gap pixel of depth zero
    `DRGI_ASSERT(a_nonb_zero, i_clk, i_rst_n, (o_out_valid && o_no_neighbour) |-> (o_was_filled && (o_filled_depth == '0)), "no-neighbour pixel not zero fill")
    // the end of a row always closes a burst
    `DRGI_ASSERT(a_row_burst, i_clk, i_rst_n, (o_out_valid && o_row_last) |-> o_burst_last, "row_last without burst_last")
    // after the last result is taken the block is ready again
    `DRGI_ASSERT(a_ready_after, i_clk, i_rst_n, (o_out_valid && i_out_ready && o_burst_last) |=> o_in_ready, "not idle after burst")

endmodule

`default_nettype wire
